// ===== hdl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants for the paged mono framebuffer
// Pixel field widths, page geometry, request kinds and result layout.
// ----------------------------------------------------------------------------
package mfb_pkg;

	// Page geometry: eight vertical pixels per byte
	localparam int PAGE_ROWS = 8;
	localparam int PAGE_SH   = $clog2(PAGE_ROWS);

	// Default panel size
	localparam int PANEL_WIDTH_DEF  = 128;
	localparam int PANEL_HEIGHT_DEF = 64;

	// Field widths
	localparam int KIND_W  = 3;
	localparam int COORD_W = 8;
	localparam int BYTE_W  = 8;

	// Stream widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 3'd0,
		KIND_COMMIT = 3'd1,
		KIND_DELTA  = 3'd2,
		KIND_CLEAR  = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	// Result of one request
	typedef struct packed {
		logic              ignored;
		logic              has_delta;
		logic [BYTE_W-1:0] read_byte;
	} res_t;

	// Address unit status for the current pixel
	typedef struct packed {
		logic              in_panel;
		logic              in_store;
		logic [BYTE_W-1:0] mask;
	} addr_info_t;

endpackage

// ===== hdl/paged_mono_framebuffer_top.sv =====
// Pixel write and front read: EXEC, then MERGE (write) or FETCH (read), then DONE; the result
// is then registered on m_tvalid. A write is a read-modify-write of one back store byte.
// No new request is taken until DONE hands the result on. Commit and delta query sweep every
// store byte (SWEEP, then DRAIN), clear in SWEEP only; one byte per cycle per RAM.
// Reset: arst_n clears control at once, then a clearing pass over all DEPTH bytes
// zeroes both stores while s_tready stays low.
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_top: double-buffered page-packed mono framebuffer
// Back and front store RAMs, address unit, sequencer and output register.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_top
	import mfb_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // pixel_x[7:0], pixel_y[15:8], pixel_on[16], zero
	input  logic [KIND_W-1:0]      s_tuser,  // kind[2:0]
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // read_byte[7:0], has_delta[8], ignored[9], zero
);

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT / PAGE_ROWS;
	localparam int AW    = $clog2(DEPTH);

	logic [COORD_W-1:0] item_x;
	logic [COORD_W-1:0] item_y;
	addr_info_t         info;
	logic [AW-1:0]      addr;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               back_we;
	logic [AW-1:0]      back_waddr;
	logic [BYTE_W-1:0]  back_wdata;
	logic [AW-1:0]      back_raddr;
	logic [BYTE_W-1:0]  back_rdata;
	logic               front_we;
	logic [AW-1:0]      front_waddr;
	logic [BYTE_W-1:0]  front_wdata;
	logic [AW-1:0]      front_raddr;
	logic [BYTE_W-1:0]  front_rdata;
	logic               m_valid_q;
	res_t               m_res_q;

	mfb_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_kind     (s_tuser),
		.in_x        (s_tdata[7:0]),
		.in_y        (s_tdata[15:8]),
		.in_on       (s_tdata[16]),
		.item_x      (item_x),
		.item_y      (item_y),
		.info        (info),
		.addr        (addr),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.back_we     (back_we),
		.back_waddr  (back_waddr),
		.back_wdata  (back_wdata),
		.back_raddr  (back_raddr),
		.back_rdata  (back_rdata),
		.front_we    (front_we),
		.front_waddr (front_waddr),
		.front_wdata (front_wdata),
		.front_raddr (front_raddr),
		.front_rdata (front_rdata)
	);

	mfb_addr #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_addr (
		.x    (item_x),
		.y    (item_y),
		.info (info),
		.addr (addr)
	);

	mfb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_back_ram (
		.clk   (clk),
		.we    (back_we),
		.waddr (back_waddr),
		.wdata (back_wdata),
		.raddr (back_raddr),
		.rdata (back_rdata)
	);

	mfb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_front_ram (
		.clk   (clk),
		.we    (front_we),
		.waddr (front_waddr),
		.wdata (front_wdata),
		.raddr (front_raddr),
		.rdata (front_rdata)
	);

	// Output register: takes a new result when empty or being drained
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(m_res_q);

endmodule

// ===== hdl/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// mfb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mfb_addr.sv =====
// ----------------------------------------------------------------------------
// mfb_addr: pixel address unit
// Maps a pixel to its page byte, bounds-checks it and builds the bit mask.
// ----------------------------------------------------------------------------
module mfb_addr
	import mfb_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic [COORD_W-1:0]                                   x,
	input  logic [COORD_W-1:0]                                   y,
	output addr_info_t                                           info,
	output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT/PAGE_ROWS)-1:0] addr
);

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT / PAGE_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PG_W  = COORD_W - PAGE_SH;
	localparam int IW    = $clog2((1 << PG_W) * PANEL_WIDTH + (1 << COORD_W));
	localparam int CW    = COORD_W + 1;

	logic [PG_W-1:0] page;
	logic [IW-1:0]   idx_full;

	// Page-packed byte index: page * width + column
	assign page     = y[COORD_W-1:PAGE_SH];
	assign idx_full = IW'(page) * IW'(PANEL_WIDTH) + IW'(x);
	assign addr     = idx_full[AW-1:0];

	// Bounds and bit select
	assign info.in_panel = (CW'(x) < CW'(PANEL_WIDTH)) && (CW'(y) < CW'(PANEL_HEIGHT));
	assign info.in_store = idx_full < IW'(DEPTH);
	assign info.mask     = BYTE_W'(1) << y[PAGE_SH-1:0];

endmodule

// ===== hdl/mfb_seq.sv =====
// ----------------------------------------------------------------------------
// mfb_seq: request sequencer
// Runs pixel read-modify-write, front reads and the full-store sweeps
// (reset clear, commit, delta compare, clear) over the two store RAMs.
// ----------------------------------------------------------------------------
module mfb_seq
	import mfb_pkg::*;
#(
	parameter int DEPTH = PANEL_WIDTH_DEF * PANEL_HEIGHT_DEF / PAGE_ROWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request side
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        in_kind,
	input  logic [COORD_W-1:0]       in_x,
	input  logic [COORD_W-1:0]       in_y,
	input  logic                     in_on,
	// address unit
	output logic [COORD_W-1:0]       item_x,
	output logic [COORD_W-1:0]       item_y,
	input  addr_info_t               info,
	input  logic [$clog2(DEPTH)-1:0] addr,
	// result side
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_t                     res,
	// back store
	output logic                     back_we,
	output logic [$clog2(DEPTH)-1:0] back_waddr,
	output logic [BYTE_W-1:0]        back_wdata,
	output logic [$clog2(DEPTH)-1:0] back_raddr,
	input  logic [BYTE_W-1:0]        back_rdata,
	// front store
	output logic                     front_we,
	output logic [$clog2(DEPTH)-1:0] front_waddr,
	output logic [BYTE_W-1:0]        front_wdata,
	output logic [$clog2(DEPTH)-1:0] front_raddr,
	input  logic [BYTE_W-1:0]        front_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_MERGE,
		ST_FETCH,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [COORD_W-1:0]  x_q;
	logic [COORD_W-1:0]  y_q;
	logic                on_q;
	logic [AW-1:0]       idx_q;
	logic [BYTE_W-1:0]   mask_q;
	logic                ok_q;
	logic [AW-1:0]       cnt_q;
	logic                p_vld_q;
	logic [AW-1:0]       p_addr_q;
	logic                diff_q;
	res_t                res_q;
	logic                diff_next;
	logic                late_commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
	assign item_x    = x_q;
	assign item_y    = y_q;

	// Running compare of the byte pair that arrived from the read ports
	assign diff_next = diff_q | (p_vld_q && (back_rdata != front_rdata));

	// Commit copies a fetched back byte to front and zeroes it in back
	assign late_commit = ((state_q == ST_SWEEP) || (state_q == ST_DRAIN)) && p_vld_q
		&& (kind_q == KIND_COMMIT);

	// RAM port control
	always_comb begin
		back_we     = 1'b0;
		back_waddr  = cnt_q;
		back_wdata  = '0;
		back_raddr  = cnt_q;
		front_we    = 1'b0;
		front_waddr = cnt_q;
		front_wdata = '0;
		front_raddr = cnt_q;
		case (state_q)
			ST_INIT: begin
				back_we  = 1'b1;
				front_we = 1'b1;
			end
			ST_EXEC: begin
				back_raddr  = addr;
				front_raddr = addr;
			end
			ST_MERGE: begin
				back_we    = ok_q;
				back_waddr = idx_q;
				back_wdata = on_q ? (back_rdata | mask_q) : (back_rdata & ~mask_q);
			end
			ST_SWEEP: begin
				if (kind_q == KIND_CLEAR) begin
					back_we  = 1'b1;
					front_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (late_commit) begin
			back_we     = 1'b1;
			back_waddr  = p_addr_q;
			back_wdata  = '0;
			front_we    = 1'b1;
			front_waddr = p_addr_q;
			front_wdata = back_rdata;
		end
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			p_vld_q <= 1'b0;
			diff_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind_t'(in_kind);
						x_q     <= in_x;
						y_q     <= in_y;
						on_q    <= in_on;
						cnt_q   <= '0;
						p_vld_q <= 1'b0;
						diff_q  <= 1'b0;
						res_q   <= '0;
						case (kind_t'(in_kind))
							KIND_WRITE, KIND_READ: begin
								state_q <= ST_EXEC;
							end
							KIND_COMMIT, KIND_DELTA, KIND_CLEAR: begin
								state_q <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_EXEC: begin
					idx_q         <= addr;
					mask_q        <= info.mask;
					ok_q          <= info.in_panel && info.in_store;
					res_q.ignored <= !info.in_panel;
					state_q       <= (kind_q == KIND_WRITE) ? ST_MERGE : ST_FETCH;
				end
				ST_MERGE: begin
					state_q <= ST_DONE;
				end
				ST_FETCH: begin
					if (ok_q) begin
						res_q.read_byte <= front_rdata;
					end
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					p_vld_q  <= 1'b1;
					p_addr_q <= cnt_q;
					diff_q   <= diff_next;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= (kind_q == KIND_CLEAR) ? ST_DONE : ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					p_vld_q         <= 1'b0;
					res_q.has_delta <= (kind_q == KIND_DELTA) && diff_next;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/mfb_checker.sv =====
// ----------------------------------------------------------------------------
// mfb_checker: port-level checks for the paged mono framebuffer
// Watches the request and result streams of the top level.
// ----------------------------------------------------------------------------
module mfb_checker
	import mfb_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A request is never taken on back-to-back cycles: s_tready is low in the cycle after a handshake
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken on back-to-back cycles");

	// Delta and out-of-panel flags come from different kinds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
		else $error("delta and ignored both set");

	// A nonzero read byte carries no flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[7:0] != 8'd0) |-> (m_tdata[9:8] == 2'b00))
		else $error("read byte with a flag set");

	// Padding bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:10] == 6'd0))
		else $error("result padding not zero");

endmodule

bind paged_mono_framebuffer_top mfb_checker u_mfb_checker (.*);
